// ===== rtl/bbe_pkg.sv =====
// Shared types and constants of the bipartite buffer engine.
`timescale 1ns / 1ps
`default_nettype none

package bbe_pkg;

  // The byte store is split into eight byte-wide banks
  localparam int unsigned NumBanks = 8;
  localparam int unsigned BankW    = $clog2(NumBanks);

  // Command codes on the input channel
  localparam logic [1:0] CMD_OFFER = 2'd0;
  localparam logic [1:0] CMD_PEEK  = 2'd1;
  localparam logic [1:0] CMD_POLL  = 2'd2;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_OFFER,
    OP_PEEK,
    OP_POLL,
    OP_REFUSE
  } bbe_op_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [3:0]  size;
    logic [63:0] payload;
  } bbe_in_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] read_bytes;
    logic [8:0]  bytes_used;
    logic        is_empty;
  } bbe_out_t;

  typedef struct packed {
    bbe_op_e     op;
    logic [3:0]  size;
    logic [63:0] payload;
  } bbe_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bbe_front.sv =====
// Front end: accepts input transfers, classifies them and queues them for the back end.
`timescale 1ns / 1ps
`default_nettype none

module bbe_front import bbe_pkg::*; #(
  parameter int unsigned MAX_CHUNK = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bbe_in_t  in_data_i,
  output logic     q_valid_o,
  input  logic     q_ready_i,
  output bbe_cmd_t q_data_o
);

  bbe_cmd_t   slot_q [2];
  logic       wr_ptr_q;
  logic       rd_ptr_q;
  logic [1:0] count_q;
  bbe_cmd_t   cls;
  logic       push;
  logic       pop;

  // Classify: oversized chunks and unknown commands are refused up front
  always_comb begin
    cls.size    = in_data_i.size;
    cls.payload = in_data_i.payload;
    if (in_data_i.size > 4'(MAX_CHUNK)) begin
      cls.op = OP_REFUSE;
    end else begin
      case (in_data_i.command)
        CMD_OFFER: cls.op = OP_OFFER;
        CMD_PEEK:  cls.op = OP_PEEK;
        CMD_POLL:  cls.op = OP_POLL;
        default:   cls.op = OP_REFUSE;
      endcase
    end
  end

  // Two-entry queue toward the back end
  assign in_ready_o = (count_q != 2'd2);
  assign q_valid_o  = (count_q != 2'd0);
  assign q_data_o   = slot_q[rd_ptr_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push && !pop) begin
        count_q <= count_q + 2'd1;
      end else if (pop && !push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/bbe_back.sv =====
// Back end: region pointers, banked byte store and the output register.
`timescale 1ns / 1ps
`default_nettype none

module bbe_back import bbe_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     q_valid_i,
  output logic     q_ready_o,
  input  bbe_cmd_t q_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bbe_out_t out_data_o
);

  localparam int unsigned PtrW = $clog2(CAPACITY + 1);
  localparam int unsigned Rows = (CAPACITY + NumBanks - 1) / NumBanks;
  localparam int unsigned RowW = (Rows > 1) ? $clog2(Rows) : 1;
  localparam logic [PtrW-1:0] CapPtr = PtrW'(CAPACITY);

  localparam logic ST_EXEC   = 1'b0;
  localparam logic ST_RESULT = 1'b1;

  logic            state_q;
  logic [PtrW-1:0] a_start_q, a_start_d;
  logic [PtrW-1:0] a_end_q, a_end_d;
  logic [PtrW-1:0] b_end_q, b_end_d;
  logic            b_act_q, b_act_d;
  logic            pend_ok_q;
  logic [BankW-1:0] pend_shift_q;
  logic [3:0]      pend_rsize_q;
  logic            out_valid_q;
  bbe_out_t        out_q;
  bbe_out_t        result;

  logic            take;
  logic [PtrW-1:0] sz;
  logic [PtrW-1:0] a_len;
  logic [PtrW-1:0] room_after, room_before, room;
  logic [PtrW-1:0] wr_base, poll_start;
  logic [PtrW-1:0] after_d, before_d;
  logic            exec_ok, rd_go, wr_go;
  logic [PtrW-1:0] mem_base, base_row;
  logic [BankW-1:0] base_lane;
  logic [PtrW:0]   used_sum;

  logic [NumBanks-1:0]           bank_we;
  logic [NumBanks-1:0][RowW-1:0] bank_row;
  logic [NumBanks-1:0][7:0]      bank_wdata;
  logic [NumBanks-1:0][7:0]      bank_rdata;

  // Take the next command only when the output register frees up
  assign q_ready_o = (state_q == ST_EXEC) && (!out_valid_q || out_ready_i);
  assign take      = q_ready_o && q_valid_i;

  // Region arithmetic on the current pointers
  assign sz          = PtrW'(q_data_i.size);
  assign a_len       = (a_end_q > a_start_q) ? a_end_q - a_start_q : '0;
  assign room_after  = (CapPtr > a_end_q) ? CapPtr - a_end_q : '0;
  assign room_before = (a_start_q > b_end_q) ? a_start_q - b_end_q : '0;
  assign room        = b_act_q ? room_before : room_after;
  assign wr_base     = b_act_q ? b_end_q : a_end_q;
  assign poll_start  = a_start_q + sz;

  // Execute one command: decide, then compute the next pointers
  always_comb begin
    exec_ok   = 1'b0;
    rd_go     = 1'b0;
    wr_go     = 1'b0;
    a_start_d = a_start_q;
    a_end_d   = a_end_q;
    b_end_d   = b_end_q;
    b_act_d   = b_act_q;
    case (q_data_i.op)
      OP_OFFER: begin
        if (room >= sz) begin
          exec_ok = 1'b1;
          wr_go   = 1'b1;
          if (b_act_q) begin
            b_end_d = wr_base + sz;
          end else begin
            a_end_d = wr_base + sz;
          end
        end
      end
      OP_PEEK, OP_POLL: begin
        if ((a_len != '0) && (sz <= a_len)) begin
          exec_ok = 1'b1;
          rd_go   = 1'b1;
          if (q_data_i.op == OP_POLL) begin
            a_start_d = poll_start;
            // Drained A: B becomes A, or A restarts at zero
            if (poll_start == a_end_q) begin
              a_start_d = '0;
              if (b_act_q) begin
                a_end_d = b_end_q;
                b_end_d = '0;
                b_act_d = 1'b0;
              end else begin
                a_end_d = '0;
              end
            end
          end
        end
      end
      default: ;
    endcase
    // Switch to B once the gap before A beats the room after A
    after_d  = (CapPtr > a_end_d) ? CapPtr - a_end_d : '0;
    before_d = (a_start_d > b_end_d) ? a_start_d - b_end_d : '0;
    if (exec_ok && (q_data_i.op != OP_PEEK) && (after_d < before_d)) begin
      b_act_d = 1'b1;
    end
  end

  // Bank addressing: lane b holds byte (b - base) mod 8 of the chunk
  assign mem_base  = (q_data_i.op == OP_OFFER) ? wr_base : a_start_q;
  assign base_lane = mem_base[BankW-1:0];
  assign base_row  = mem_base >> BankW;

  always_comb begin
    logic [BankW-1:0] off;
    logic [PtrW-1:0]  row_full;
    for (int b = 0; b < NumBanks; b++) begin
      off           = BankW'(b) - base_lane;
      row_full      = base_row + PtrW'(BankW'(b) < base_lane);
      bank_row[b]   = RowW'(row_full);
      bank_we[b]    = take && wr_go && (4'(off) < q_data_i.size);
      bank_wdata[b] = q_data_i.payload[8*off +: 8];
    end
  end

  // Byte store: one bank per byte lane, one access per bank per cycle
  for (genvar gb = 0; gb < NumBanks; gb++) begin : g_bank
    logic [7:0] store_q [Rows];
    logic [7:0] rd_q;
    always_ff @(posedge clk_i) begin
      if (bank_we[gb]) begin
        store_q[bank_row[gb]] <= bank_wdata[gb];
      end
      if (take && rd_go) begin
        rd_q <= store_q[bank_row[gb]];
      end
    end
    assign bank_rdata[gb] = rd_q;
  end

  // Result assembly from the registered bank data and updated pointers
  assign used_sum = {1'b0, a_len} + {1'b0, b_end_q};

  always_comb begin
    logic [BankW-1:0] lane;
    result.ok         = pend_ok_q;
    result.bytes_used = 9'(used_sum);
    result.is_empty   = (a_start_q == a_end_q);
    for (int k = 0; k < NumBanks; k++) begin
      lane = BankW'(k) + pend_shift_q;
      result.read_bytes[8*k +: 8] = (4'(k) < pend_rsize_q) ? bank_rdata[lane] : 8'h00;
    end
  end

  // Per-command payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      pend_ok_q    <= exec_ok;
      pend_shift_q <= base_lane;
      pend_rsize_q <= rd_go ? q_data_i.size : 4'd0;
    end
    if (state_q == ST_RESULT) begin
      out_q <= result;
    end
  end

  // Control state and region pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_EXEC;
      a_start_q   <= '0;
      a_end_q     <= '0;
      b_end_q     <= '0;
      b_act_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_EXEC: begin
          if (take) begin
            state_q   <= ST_RESULT;
            a_start_q <= a_start_d;
            a_end_q   <= a_end_d;
            b_end_q   <= b_end_d;
            b_act_q   <= b_act_d;
          end
        end
        ST_RESULT: state_q <= ST_EXEC;
        default:   state_q <= ST_EXEC;
      endcase
      if (state_q == ST_RESULT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== rtl/bipartite_buffer_engine.sv =====
// Top level of the bipartite buffer engine: front queue plus execution back end.
// Usage:
//   Input channel (in_valid_i / in_ready_o / in_data_i) carries one command per
//   transfer: offer (append up to eight bytes), peek or poll (read from the
//   start of region A). Output channel (out_valid_o / out_ready_i / out_data_o)
//   returns exactly one result per command, in order: ok, read bytes, bytes
//   held and the empty flag.
//   A command passes through a queue slot, the bank read registers and the
//   output register before its result is valid.
//   The back end takes no new command while in its result state, where the
//   registered bank read data is assembled.
//   A two-entry queue sits between front and back, so commands are taken while
//   a result waits in the output register.
//   Reset clears all region pointers and the queue; the store content is left
//   as is and is never read before it is written.
//   When the receiver stalls, the result holds in the output register, the
//   back end stops, and the queue fills and then drops in_ready_o.
`timescale 1ns / 1ps
`default_nettype none

module bipartite_buffer_engine import bbe_pkg::*; #(
  parameter int unsigned CAPACITY  = 256,
  parameter int unsigned MAX_CHUNK = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  bbe_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output bbe_out_t out_data_o
);

  logic     q_valid;
  logic     q_ready;
  bbe_cmd_t q_data;

  bbe_front #(
    .MAX_CHUNK(MAX_CHUNK)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_data_i (in_data_i),
    .q_valid_o (q_valid),
    .q_ready_i (q_ready),
    .q_data_o  (q_data)
  );

  bbe_back #(
    .CAPACITY(CAPACITY)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_ready_o  (q_ready),
    .q_data_i   (q_data),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

endmodule

`default_nettype wire

// ===== rtl/bbe_checker.sv =====
// Port-level checks for the bipartite buffer engine, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module bbe_checker import bbe_pkg::*; #(
  parameter int unsigned CAPACITY = 256
) (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input bbe_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input bbe_out_t out_data_o
);

  // A waiting command stays offered and unchanged
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("command changed while waiting");

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result changed while stalled");

  // A refused command returns no data
  a_refuse_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.ok |-> out_data_o.read_bytes == 64'd0)
    else $error("refused command returned data");

  // Region B only holds data while A does, so empty A means empty buffer
  a_empty_used: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.is_empty == (out_data_o.bytes_used == 9'd0))
    else $error("empty flag disagrees with byte count");

  // Never more bytes held than the store has
  a_used_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (CAPACITY > 511) || (32'(out_data_o.bytes_used) <= CAPACITY))
    else $error("byte count exceeds capacity");

endmodule

bind bipartite_buffer_engine bbe_checker #(
  .CAPACITY(CAPACITY)
) u_bbe_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .in_data_i  (in_data_i),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_data_o (out_data_o)
);

`default_nettype wire
